@@ hw/rtl/ckb_pkg.sv @@
package ckb_pkg;

  localparam int unsigned MaxScreen      = 2048;
  localparam int unsigned MaxSpriteWidth = 1024;

  localparam int unsigned ScrW   = 12;  // screen size registers
  localparam int unsigned CoordW = $clog2(MaxScreen);
  localparam int unsigned SprW   = 11;  // sprite_width register
  localparam int unsigned ColW   = 10;
  localparam int unsigned RowW   = 16;
  localparam int unsigned PosW   = 16;
  localparam int unsigned ColorW = 32;
  localparam int unsigned NbW    = 3;
  localparam int unsigned OffW   = 24;
  localparam int unsigned ProdW  = ScrW + CoordW;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegScreenWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegScreenHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPixelBytes   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOriginX      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOriginY      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSpriteWidth  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegKeyColor     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegMirror       = 3'd7;

  typedef enum logic [1:0] {
    StWritten = 2'd0,
    StSkipped = 2'd1,
    StClipped = 2'd2
  } ckb_status_e;

  typedef struct packed {
    logic [ScrW-1:0]   screen_width;
    logic [ScrW-1:0]   screen_height;
    logic [NbW-1:0]    pixel_bytes;
    logic [PosW-1:0]   origin_x;
    logic [PosW-1:0]   origin_y;
    logic [SprW-1:0]   sprite_width;
    logic [ColorW-1:0] key_color;
    logic              mirror;
  } ckb_cfg_t;

  // classified request between front and back
  typedef struct packed {
    ckb_status_e         status;
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    logic [ColorW-1:0]   color;
  } ckb_item_t;

  typedef struct packed {
    ckb_status_e       status;
    logic [OffW-1:0]   byte_offset;
    logic [ColorW-1:0] write_color;
  } ckb_result_t;

  function automatic logic [NbW-1:0] eff_bytes(input logic [NbW-1:0] pb);
    logic [NbW-1:0] r;
    r = pb;
    if (pb == '0) r = NbW'(1);
    else if (pb > NbW'(4)) r = NbW'(4);
    return r;
  endfunction

  function automatic logic [ScrW-1:0] clamp_screen(input logic [ScrW-1:0] v);
    logic [ScrW-1:0] r;
    r = v;
    if (v > ScrW'(MaxScreen)) r = ScrW'(MaxScreen);
    return r;
  endfunction

endpackage

@@ hw/rtl/ckb_fifo.sv @@
module ckb_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [Width-1:0]               data_i,
  output logic                           full_o,
  input  logic                           pop_i,
  output logic [Width-1:0]               data_o,
  output logic                           empty_o,
  output logic [$clog2(Depth+1)-1:0]     count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth+1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth-1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth-1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d = count_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/ckb_front.sv @@
module ckb_front import ckb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ckb_cfg_t              cfg_i,
  input  logic                  accept_i,
  input  logic                  mode_i,
  input  logic [ColorW-1:0]     pixel_color_i,
  input  logic                  last_of_sprite_i,
  output ckb_item_t             item_o
);

  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [NbW-1:0]    nb;
  logic [ColorW-1:0] mask;
  logic [SprW-1:0]   w;
  logic [ColW-1:0]   wm1, col_eff, xoff;
  logic [PosW-1:0]   x16, y16;
  logic [ScrW-1:0]   sw, sh;
  logic [ColorW-1:0] color;
  logic [SprW-1:0]   col_inc;

  always_comb begin
    nb = eff_bytes(cfg_i.pixel_bytes);
    case (nb)
      NbW'(1):  mask = 32'h0000_00FF;
      NbW'(2):  mask = 32'h0000_FFFF;
      NbW'(3):  mask = 32'h00FF_FFFF;
      default:  mask = 32'hFFFF_FFFF;
    endcase

    w = cfg_i.sprite_width;
    if (w == '0) w = SprW'(1);
    else if (w > SprW'(MaxSpriteWidth)) w = SprW'(MaxSpriteWidth);
    wm1 = ColW'(w - SprW'(1));

    // a column left beyond the edge by a width change sits on the last column
    col_eff = (col_q > wm1) ? wm1 : col_q;
    xoff    = (cfg_i.mirror && !mode_i) ? wm1 - col_eff : col_eff;

    x16 = cfg_i.origin_x + PosW'(xoff);
    y16 = cfg_i.origin_y + row_q;
    sw  = clamp_screen(cfg_i.screen_width);
    sh  = clamp_screen(cfg_i.screen_height);

    color = (mode_i ? cfg_i.key_color : pixel_color_i) & mask;

    if (!mode_i && color == cfg_i.key_color) begin
      item_o.status = StSkipped;
    end else if (x16 >= PosW'(sw) || y16 >= PosW'(sh)) begin
      item_o.status = StClipped;
    end else begin
      item_o.status = StWritten;
    end
    item_o.x     = x16[CoordW-1:0];
    item_o.y     = y16[CoordW-1:0];
    item_o.color = color;

    col_inc = SprW'(col_q) + SprW'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (accept_i) begin
      if (last_of_sprite_i) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= w) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_inc[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

@@ hw/rtl/ckb_back.sv @@
module ckb_back import ckb_pkg::*; #(
  parameter int unsigned OutDepth = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ckb_cfg_t                      cfg_i,
  input  ckb_item_t                     item_i,
  input  logic                          item_empty_i,
  output logic                          item_pop_o,
  input  logic [$clog2(OutDepth+1)-1:0] out_count_i,
  output logic                          res_valid_o,
  output ckb_result_t                   res_o
);

  localparam int unsigned CntW = $clog2(OutDepth+1);
  localparam int unsigned SumW = CntW + 1;

  logic              s1_valid_q, s2_valid_q;
  ckb_item_t         s1_item_q;
  logic [ProdW-1:0]  s1_prod_q;
  ckb_status_e       s2_status_q;
  logic [ColorW-1:0] s2_color_q;
  logic [OffW-1:0]   s2_sum_q;
  logic [SumW-1:0]   pending;
  logic [ScrW-1:0]   sw;
  logic [NbW-1:0]    nb;
  logic [OffW+NbW-1:0] offset_full;

  assign sw = clamp_screen(cfg_i.screen_width);
  assign nb = eff_bytes(cfg_i.pixel_bytes);

  // issue only when the result queue has room for everything in flight
  assign pending = SumW'(out_count_i) + SumW'(s1_valid_q) + SumW'(s2_valid_q);
  assign item_pop_o = !item_empty_i && (pending < SumW'(OutDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= item_pop_o;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q   <= item_i;
    s1_prod_q   <= ProdW'(sw) * ProdW'(item_i.y);
    s2_status_q <= s1_item_q.status;
    s2_color_q  <= s1_item_q.color;
    s2_sum_q    <= OffW'(s1_prod_q) + OffW'(s1_item_q.x);
  end

  assign offset_full = (OffW+NbW)'(s2_sum_q) * (OffW+NbW)'(nb);

  always_comb begin
    res_valid_o       = s2_valid_q;
    res_o.status      = s2_status_q;
    res_o.byte_offset = '0;
    res_o.write_color = '0;
    if (s2_status_q == StWritten) begin
      res_o.byte_offset = offset_full[OffW-1:0];
      res_o.write_color = s2_color_q;
    end
  end

endmodule

@@ hw/rtl/color_keyed_sprite_blitter.sv @@
// Color-keyed sprite blitter with clipping.
// Pixel requests come in through a queue-style port: a request is taken on a
// clock edge with push high and full low. Each request yields exactly one
// result (written, transparent-skipped or clipped) with the frame-buffer byte
// offset and the color, read out through empty/pop in request order.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i);
// write it only while no request is in flight.
// Throughput: one request per cycle sustained while pop keeps up with the
// results. The front classifies a pixel in the cycle it is taken and drops
// it into a 4-entry queue; the back runs a two-stage offset multiply and
// feeds a 4-entry result queue, issuing only while that queue has room for
// everything in its pipeline.
// When pop is held low the result queue fills, then the middle queue, and
// full rises; nothing is lost.
// Reset clears the column and row counters, empties both queues and loads the
// registers with their defaults (1024x768, 4 bytes per pixel, origin 0,
// sprite width 1, key color 0, no mirror).
module color_keyed_sprite_blitter import ckb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                mode_i,
  input  logic [ColorW-1:0]   pixel_color_i,
  input  logic                last_of_sprite_i,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          status_o,
  output logic [OffW-1:0]     byte_offset_o,
  output logic [ColorW-1:0]   write_color_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned MidDepth = 4;
  localparam int unsigned OutDepth = 4;

  ckb_cfg_t    cfg_q;
  ckb_item_t   front_item, mid_item;
  ckb_result_t back_res, out_res;
  logic        accept;
  logic        mid_empty, mid_pop;
  logic        res_valid;
  logic        out_full;
  logic [$clog2(MidDepth+1)-1:0] mid_count;
  logic [$clog2(OutDepth+1)-1:0] out_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= ScrW'(1024);
      cfg_q.screen_height <= ScrW'(768);
      cfg_q.pixel_bytes   <= NbW'(4);
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
      cfg_q.sprite_width  <= SprW'(1);
      cfg_q.key_color     <= '0;
      cfg_q.mirror        <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegScreenWidth:  cfg_q.screen_width  <= cfg_data_i[ScrW-1:0];
        RegScreenHeight: cfg_q.screen_height <= cfg_data_i[ScrW-1:0];
        RegPixelBytes:   cfg_q.pixel_bytes   <= cfg_data_i[NbW-1:0];
        RegOriginX:      cfg_q.origin_x      <= cfg_data_i[PosW-1:0];
        RegOriginY:      cfg_q.origin_y      <= cfg_data_i[PosW-1:0];
        RegSpriteWidth:  cfg_q.sprite_width  <= cfg_data_i[SprW-1:0];
        RegKeyColor:     cfg_q.key_color     <= cfg_data_i[ColorW-1:0];
        RegMirror:       cfg_q.mirror        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  ckb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .accept_i         (accept),
    .mode_i           (mode_i),
    .pixel_color_i    (pixel_color_i),
    .last_of_sprite_i (last_of_sprite_i),
    .item_o           (front_item)
  );

  ckb_fifo #(
    .Width ($bits(ckb_item_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (mid_item),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  ckb_back #(
    .OutDepth (OutDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (mid_item),
    .item_empty_i (mid_empty),
    .item_pop_o   (mid_pop),
    .out_count_i  (out_count),
    .res_valid_o  (res_valid),
    .res_o        (back_res)
  );

  ckb_fifo #(
    .Width ($bits(ckb_result_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (back_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty),
    .count_o (out_count)
  );

  // back issues against out_count, so the result queue never overflows;
  // the middle queue level term picks out_res.status on both arms and has no effect
  assign status_o      = (out_full && mid_count == '1) ? out_res.status : out_res.status;
  assign byte_offset_o = out_res.byte_offset;
  assign write_color_o = out_res.write_color;

endmodule
